// ----- design/bezier_curve_point_eval_core_defines.svh -----
// assertion macros for the bezier curve point evaluator
// no dependencies; taken in by `include where a module checks itself
`ifndef BEZIER_CURVE_POINT_EVAL_CORE_DEFINES_SVH
`define BEZIER_CURVE_POINT_EVAL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BCPE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcpe assertion failed");
`define BCPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcpe assertion failed");
`else
`define BCPE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BCPE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/bcpe_pkg.sv -----
// shared types and constants for the bezier curve point evaluator
// no dependencies; used by bcpe_ctrl, bcpe_datapath and the top level
package bcpe_pkg;

    localparam int PIDX_W = 3;
    localparam int CFG_W  = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef struct packed {
        logic start;
        logic store_wr;
        logic pow_step;
        logic sum_issue;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_valid;
    } t_dp_status;

    // default cubic curve held after reset
    function automatic int reset_x(input int idx);
        int val;
        case (idx)
            2: val = 1;
            3: val = 1;
            default: val = 0;
        endcase
        return val;
    endfunction

    function automatic int reset_y(input int idx);
        int val;
        case (idx)
            1: val = 1;
            2: val = -1;
            default: val = 0;
        endcase
        return val;
    endfunction

endpackage

// ----- design/bezier_curve_point_eval_core.sv -----
// top level of the bezier curve point evaluator (bernstein form, fixed point)
// depends on bcpe_pkg, bcpe_ctrl and bcpe_datapath
//
// usage:
//   s_axis carries requests; tuser selects load (0) or evaluate (1). a load writes
//   one control point into the store and gives no result; an evaluate returns one
//   point on m_axis. i_cfg_we/i_cfg_wdata write the control point count (curve
//   degree + 1); the user must write them only while the block is idle, as the block
//   itself does not enforce this. an evaluate runs from acceptance to m_axis_tvalid
//   as n - 1 power steps through one multiplier per power, n being the clamped point
//   count, then n issues into a four-stage weight/product/accumulate pipeline, drain,
//   then round and saturate into the output register. the next request is taken the
//   cycle after the result is loaded; no new request is taken while an evaluate runs.
//   the result waits in the output register while m_axis_tready is low; the block
//   still takes loads and computes the next evaluate, holding it until the
//   register frees.
//   reset sets the point count to 4 and loads the default cubic control points.
module bezier_curve_point_eval_core #(
    parameter int MAX_POINTS  = 8,
    parameter int COORD_BITS  = 16,
    parameter int T_FRAC_BITS = 16,
    localparam int TW          = T_FRAC_BITS + 1,
    localparam int IN_W        = bcpe_pkg::PIDX_W + 2*COORD_BITS + TW,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((2*COORD_BITS + 7) / 8) * 8,
    localparam int CNT_W       = $clog2(MAX_POINTS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // point_index, coord_x, coord_y, t_frac, zero pad
    input  logic [IN_TDATA_W-1:0]       s_axis_tdata,
    // req_type
    input  logic [0:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // pos_x, pos_y, zero pad
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic                        i_cfg_we,
    input  logic [bcpe_pkg::CFG_W-1:0]  i_cfg_wdata
);

    localparam int X_LSB = bcpe_pkg::PIDX_W;
    localparam int Y_LSB = X_LSB + COORD_BITS;
    localparam int T_LSB = Y_LSB + COORD_BITS;

    bcpe_pkg::t_dp_cmd            cmd;
    bcpe_pkg::t_dp_status         status;
    logic [CNT_W-1:0]             idx, deg;
    logic [bcpe_pkg::PIDX_W-1:0]  point_index;
    logic signed [COORD_BITS-1:0] coord_x, coord_y, pos_x, pos_y;
    logic [TW-1:0]                t_frac;

    assign point_index = s_axis_tdata[bcpe_pkg::PIDX_W-1:0];
    assign coord_x     = $signed(s_axis_tdata[X_LSB +: COORD_BITS]);
    assign coord_y     = $signed(s_axis_tdata[Y_LSB +: COORD_BITS]);
    assign t_frac      = s_axis_tdata[T_LSB +: TW];

    bcpe_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_axis_tvalid),
        .i_req_type  (s_axis_tuser[0]),
        .o_s_ready   (s_axis_tready),
        .i_m_tready  (m_axis_tready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_idx       (idx),
        .o_deg       (deg)
    );

    bcpe_datapath #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_idx         (idx),
        .i_deg         (deg),
        .i_point_index (point_index),
        .i_coord_x     (coord_x),
        .i_coord_y     (coord_y),
        .i_t_frac      (t_frac),
        .i_m_tready    (m_axis_tready),
        .o_status      (status),
        .o_pos_x       (pos_x),
        .o_pos_y       (pos_y)
    );

    assign m_axis_tvalid = status.out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({pos_y, pos_x});

endmodule

// ----- design/bcpe_datapath.sv -----
// datapath: control point store, power tables, pascal row, weight/product pipeline,
// accumulators and output register; driven by bcpe_ctrl commands
// depends on bcpe_pkg
module bcpe_datapath #(
    parameter int MAX_POINTS  = 8,
    parameter int COORD_BITS  = 16,
    parameter int T_FRAC_BITS = 16,
    localparam int CNT_W = $clog2(MAX_POINTS),
    localparam int TW    = T_FRAC_BITS + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bcpe_pkg::t_dp_cmd             i_cmd,
    input  logic [CNT_W-1:0]              i_idx,
    input  logic [CNT_W-1:0]              i_deg,
    input  logic [bcpe_pkg::PIDX_W-1:0]   i_point_index,
    input  logic signed [COORD_BITS-1:0]  i_coord_x,
    input  logic signed [COORD_BITS-1:0]  i_coord_y,
    input  logic [TW-1:0]                 i_t_frac,
    input  logic                          i_m_tready,
    output bcpe_pkg::t_dp_status          o_status,
    output logic signed [COORD_BITS-1:0]  o_pos_x,
    output logic signed [COORD_BITS-1:0]  o_pos_y
);

    localparam int BW    = MAX_POINTS - 1;
    localparam int WW    = BW + TW;
    localparam int PW    = WW + 1 + COORD_BITS;
    localparam int ACC_W = PW + 1;
    localparam int QW    = ACC_W - T_FRAC_BITS;

    localparam logic [TW-1:0]            ONE    = TW'(1) << T_FRAC_BITS;
    localparam logic [2*TW-1:0]          HALF2  = (2*TW)'(1) << (T_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0]  HALF_A = ACC_W'(1) << (T_FRAC_BITS - 1);

    logic signed [COORD_BITS-1:0] r_x_store [MAX_POINTS];
    logic signed [COORD_BITS-1:0] r_y_store [MAX_POINTS];

    logic [TW-1:0] r_t, r_u, r_cur_t, r_cur_u;
    logic [TW-1:0] r_pu [MAX_POINTS];
    logic [TW-1:0] r_pt [MAX_POINTS];
    logic [BW-1:0] r_row [MAX_POINTS];

    logic                         r_v1, r_v2, r_v3;
    logic [TW-1:0]                r_k;
    logic [BW-1:0]                r_k_binom;
    logic signed [COORD_BITS-1:0] r_s1_px, r_s1_py, r_s2_px, r_s2_py;
    logic [WW-1:0]                r_w;
    logic signed [PW-1:0]         r_prod_x, r_prod_y;
    logic signed [ACC_W-1:0]      r_acc_x, r_acc_y;

    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_pos_x, r_pos_y;

    logic [TW-1:0]        t_sat, u_next;
    logic [2*TW-1:0]      pu_prod, pt_prod, k_prod;
    logic [TW-1:0]        pu_next, pt_next, k_next;
    logic [CNT_W-1:0]     lo_idx;
    logic [WW-1:0]        w_next;
    logic signed [PW-1:0] w_s, px_e, py_e, prod_x_next, prod_y_next;
    logic signed [COORD_BITS-1:0] pos_x_next, pos_y_next;

    // t above one saturates to one
    assign t_sat  = (i_t_frac > ONE) ? ONE : i_t_frac;
    assign u_next = ONE - t_sat;

    assign pu_prod = {{TW{1'b0}}, r_cur_u} * {{TW{1'b0}}, r_u} + HALF2;
    assign pt_prod = {{TW{1'b0}}, r_cur_t} * {{TW{1'b0}}, r_t} + HALF2;
    assign pu_next = pu_prod[T_FRAC_BITS +: TW];
    assign pt_next = pt_prod[T_FRAC_BITS +: TW];

    assign lo_idx = i_deg - i_idx;
    assign k_prod = {{TW{1'b0}}, r_pu[lo_idx]} * {{TW{1'b0}}, r_pt[i_idx]} + HALF2;
    assign k_next = k_prod[T_FRAC_BITS +: TW];

    assign w_next = {{TW{1'b0}}, r_k_binom} * {{BW{1'b0}}, r_k};

    assign w_s         = PW'($signed({1'b0, r_w}));
    assign px_e        = PW'(r_s2_px);
    assign py_e        = PW'(r_s2_py);
    assign prod_x_next = w_s * px_e;
    assign prod_y_next = w_s * py_e;

    function automatic logic signed [COORD_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] rnd;
        logic signed [QW-1:0]    q;
        logic signed [COORD_BITS-1:0] res;
        rnd = acc + HALF_A;
        q   = rnd[ACC_W-1:T_FRAC_BITS];
        if (!q[QW-1] && (|q[QW-2:COORD_BITS-1])) begin
            res = {1'b0, {(COORD_BITS-1){1'b1}}};
        end else if (q[QW-1] && !(&q[QW-2:COORD_BITS-1])) begin
            res = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            res = q[COORD_BITS-1:0];
        end
        return res;
    endfunction

    assign pos_x_next = round_sat(r_acc_x);
    assign pos_y_next = round_sat(r_acc_y);

    // control point store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_POINTS; j++) begin
                r_x_store[j] <= COORD_BITS'(bcpe_pkg::reset_x(j));
                r_y_store[j] <= COORD_BITS'(bcpe_pkg::reset_y(j));
            end
        end else if (i_cmd.store_wr) begin
            for (int j = 0; j < MAX_POINTS; j++) begin
                if (int'(i_point_index) == j) begin
                    r_x_store[j] <= i_coord_x;
                    r_y_store[j] <= i_coord_y;
                end
            end
        end
    end

    // power tables and pascal row
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_t     <= t_sat;
            r_u     <= u_next;
            r_cur_t <= ONE;
            r_cur_u <= ONE;
            r_pu[0] <= ONE;
            r_pt[0] <= ONE;
            for (int j = 0; j < MAX_POINTS; j++) begin
                r_row[j] <= (j == 0) ? BW'(1) : '0;
            end
        end else if (i_cmd.pow_step) begin
            r_cur_u     <= pu_next;
            r_cur_t     <= pt_next;
            r_pu[i_idx] <= pu_next;
            r_pt[i_idx] <= pt_next;
            for (int j = 1; j < MAX_POINTS; j++) begin
                r_row[j] <= r_row[j] + r_row[j-1];
            end
        end
    end

    // weight, product and accumulate pipeline and output register
    always_ff @(posedge i_clk) begin
        r_k       <= k_next;
        r_k_binom <= r_row[i_idx];
        r_s1_px   <= r_x_store[i_idx];
        r_s1_py   <= r_y_store[i_idx];
        r_w       <= w_next;
        r_s2_px   <= r_s1_px;
        r_s2_py   <= r_s1_py;
        r_prod_x  <= prod_x_next;
        r_prod_y  <= prod_y_next;
        if (i_cmd.start) begin
            r_acc_x <= '0;
            r_acc_y <= '0;
        end else if (r_v3) begin
            r_acc_x <= r_acc_x + ACC_W'(r_prod_x);
            r_acc_y <= r_acc_y + ACC_W'(r_prod_y);
        end
        if (i_cmd.out_load) begin
            r_pos_x <= pos_x_next;
            r_pos_y <= pos_y_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.sum_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.pipe_busy = r_v1 | r_v2 | r_v3;
    assign o_status.out_valid = r_out_valid;
    assign o_pos_x = r_pos_x;
    assign o_pos_y = r_pos_y;

endmodule

// ----- design/bcpe_ctrl.sv -----
// controller: point count register, sequencing of power, sum, drain and output steps
// depends on bcpe_pkg and bezier_curve_point_eval_core_defines.svh
`include "bezier_curve_point_eval_core_defines.svh"
module bcpe_ctrl #(
    parameter int MAX_POINTS = 8,
    localparam int CNT_W = $clog2(MAX_POINTS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_valid,
    input  logic                        i_req_type,
    output logic                        o_s_ready,
    input  logic                        i_m_tready,
    input  logic                        i_cfg_we,
    input  logic [bcpe_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  bcpe_pkg::t_dp_status        i_status,
    output bcpe_pkg::t_dp_cmd           o_cmd,
    output logic [CNT_W-1:0]            o_idx,
    output logic [CNT_W-1:0]            o_deg
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_POW   = 5'b00010,
        ST_SUM   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_FIN   = 5'b10000
    } t_state;

    localparam logic [4:0] MIN_N = 5'd2;
    localparam logic [4:0] MAX_N = 5'(MAX_POINTS);

    t_state                      r_state, n_state;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [CNT_W-1:0]            r_deg, n_deg;
    logic [bcpe_pkg::CFG_W-1:0]  r_curve_pts;
    logic [4:0]                  n_clamp;
    logic [CNT_W-1:0]            deg_next;

    // out-of-range point counts clamp to 2..MAX_POINTS
    always_comb begin
        if ({1'b0, r_curve_pts} < MIN_N) begin
            n_clamp = MIN_N;
        end else if ({1'b0, r_curve_pts} > MAX_N) begin
            n_clamp = MAX_N;
        end else begin
            n_clamp = {1'b0, r_curve_pts};
        end
        deg_next = CNT_W'(n_clamp - 5'd1);
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_deg   = r_deg;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    if (i_req_type == bcpe_pkg::REQ_EVAL) begin
                        o_cmd.start = 1'b1;
                        n_deg       = deg_next;
                        n_cnt       = CNT_W'(1);
                        n_state     = ST_POW;
                    end else begin
                        o_cmd.store_wr = 1'b1;
                    end
                end
            end
            ST_POW: begin
                o_cmd.pow_step = 1'b1;
                if (r_cnt == r_deg) begin
                    n_cnt   = '0;
                    n_state = ST_SUM;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_SUM: begin
                o_cmd.sum_issue = 1'b1;
                if (r_cnt == r_deg) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // wait for the output register to free up
                if (!i_status.out_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_deg       <= '0;
            r_curve_pts <= bcpe_pkg::CFG_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_deg   <= n_deg;
            if (i_cfg_we) begin
                r_curve_pts <= i_cfg_wdata;
            end
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_idx     = r_cnt;
    assign o_deg     = r_deg;

    `BCPE_ASSERT_IMPL(a_out_slot_free, i_clk, i_rst_n, o_cmd.out_load,
        !i_status.out_valid || i_m_tready)
    `BCPE_ASSERT_NEXT(a_eval_starts, i_clk, i_rst_n,
        r_state == ST_IDLE && i_s_valid && i_req_type == bcpe_pkg::REQ_EVAL,
        r_state == ST_POW)
    `BCPE_ASSERT_IMPL(a_idle_pipe_empty, i_clk, i_rst_n, r_state == ST_IDLE,
        !i_status.pipe_busy)
    `BCPE_ASSERT_IMPL(a_cnt_in_range, i_clk, i_rst_n,
        r_state == ST_POW || r_state == ST_SUM, r_cnt <= r_deg)

endmodule
